[src/scp_pkg.sv]
// Package with the character codes, parser phases and status codes of the speed command parser.
`default_nettype none

package scp_pkg;

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChS     = 8'h73;
  localparam logic [7:0] ChR     = 8'h72;

  localparam int unsigned SpeedW = 32;
  localparam int unsigned WideW  = SpeedW + 5;

  typedef enum logic [2:0] {
    PH_START       = 3'd0,
    PH_AFTER_S     = 3'd1,
    PH_LEFT_FIRST  = 3'd2,
    PH_LEFT_BODY   = 3'd3,
    PH_RIGHT_FIRST = 3'd4,
    PH_RIGHT_BODY  = 3'd5,
    PH_WAIT_RESET  = 3'd6,
    PH_BAD         = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ST_SPEED = 2'd0,
    ST_RESET = 2'd1,
    ST_BAD   = 2'd2
  } status_e;

endpackage

`default_nettype wire

[src/speed_command_parser_top.sv]
// Speed command parser: turns received serial bytes into left and right speed commands.
//
// One received byte is taken per beat on the input channel, and a new byte can be taken in
// every clock cycle unless a byte that ends a line is held back. A byte is first registered
// in an input register; the line parser then updates its phase and running value and, when a
// carriage return ends a line, loads the result register. A result therefore passes through
// the input register and then the result register before it appears on the output. While a
// result waits for the output side, further bytes that do not end a line are still parsed;
// a byte that ends a line waits in the input register until the pending result has been
// taken. Speeds are given in thousandths and saturate at plus or minus (2^31 - 1); the status
// tells a speed command, a reset command and a malformed line apart.
`default_nettype none

module speed_command_parser_top
  import scp_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [7:0]               rx_byte_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [SpeedW-1:0]      left_milli_o,
  output logic signed [SpeedW-1:0]      right_milli_o,
  output logic [1:0]                    status_o
);

  localparam logic signed [WideW-1:0] SatMax = WideW'(64'sd2147483647);
  localparam logic signed [WideW-1:0] SatMin = -SatMax;

  logic                     in_valid_q;
  logic [7:0]               in_byte_q;
  logic                     out_valid_q;
  logic signed [SpeedW-1:0] left_q, right_q;
  status_e                  status_q;

  phase_e                   phase_q, phase_d;
  logic                     neg_q, neg_d;
  logic signed [SpeedW-1:0] acc_q, acc_d;
  logic signed [SpeedW-1:0] hold_q, hold_d;

  logic                     emit;
  logic signed [SpeedW-1:0] emit_left, emit_right;
  status_e                  emit_status;
  logic                     advance;
  logic                     is_digit;

  logic signed [8:0]        digit;
  logic signed [WideW-1:0]  acc_wide, acc_sum;
  logic signed [SpeedW-1:0] acc_next;

  assign is_digit = (in_byte_q >= ChZero) && (in_byte_q <= ChNine);
  assign digit    = $signed({1'b0, in_byte_q}) - $signed({1'b0, ChZero});
  assign acc_wide = WideW'(acc_q);
  assign acc_sum  = (acc_wide <<< 3) + (acc_wide <<< 1)
                  + (neg_q ? -WideW'(digit) : WideW'(digit));

  always_comb begin
    if (acc_sum > SatMax) begin
      acc_next = SpeedW'(SatMax);
    end else if (acc_sum < SatMin) begin
      acc_next = SpeedW'(SatMin);
    end else begin
      acc_next = acc_sum[SpeedW-1:0];
    end
  end

  always_comb begin
    phase_d     = phase_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    hold_d      = hold_q;
    emit        = 1'b0;
    emit_left   = '0;
    emit_right  = '0;
    emit_status = ST_BAD;
    if (in_valid_q && (in_byte_q != ChLf)) begin
      if (in_byte_q == ChCr) begin
        emit = 1'b1;
        if (phase_q == PH_RIGHT_BODY) begin
          emit_left   = hold_q;
          emit_right  = acc_q;
          emit_status = ST_SPEED;
        end else if (phase_q == PH_WAIT_RESET) begin
          emit_status = ST_RESET;
        end
        phase_d = PH_START;
        neg_d   = 1'b0;
        acc_d   = '0;
      end else begin
        case (phase_q)
          PH_START: begin
            if (in_byte_q == ChS) begin
              phase_d = PH_AFTER_S;
            end else if (in_byte_q == ChR) begin
              phase_d = PH_WAIT_RESET;
            end else begin
              phase_d = PH_BAD;
            end
          end
          PH_AFTER_S: begin
            phase_d = (in_byte_q == ChSpace) ? PH_LEFT_FIRST : PH_BAD;
          end
          PH_LEFT_FIRST, PH_RIGHT_FIRST: begin
            if (in_byte_q == ChMinus) begin
              neg_d   = 1'b1;
              acc_d   = '0;
              phase_d = (phase_q == PH_LEFT_FIRST) ? PH_LEFT_BODY : PH_RIGHT_BODY;
            end else if (is_digit) begin
              neg_d   = 1'b0;
              acc_d   = SpeedW'(digit);
              phase_d = (phase_q == PH_LEFT_FIRST) ? PH_LEFT_BODY : PH_RIGHT_BODY;
            end else begin
              phase_d = PH_BAD;
            end
          end
          PH_LEFT_BODY: begin
            if (in_byte_q == ChSpace) begin
              hold_d  = acc_q;
              phase_d = PH_RIGHT_FIRST;
            end else begin
              acc_d = acc_next;
            end
          end
          PH_RIGHT_BODY: begin
            acc_d = acc_next;
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  assign advance    = in_valid_q && (!emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_START;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      hold_q      <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
        hold_q  <= hold_d;
      end
      if (advance && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance && emit) begin
      left_q   <= emit_left;
      right_q  <= emit_right;
      status_q <= emit_status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_milli_o  = left_q;
  assign right_milli_o = right_q;
  assign status_o      = status_q;

  a_line_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |=> (phase_q == PH_START && acc_q == '0 && !neg_q))
    else $error("parser did not return to the start of a line after a result");

  a_zero_speeds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != ST_SPEED) |-> (left_q == '0 && right_q == '0))
    else $error("non-zero speeds with a reset or malformed status");

  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (status_q == ST_SPEED || status_q == ST_RESET || status_q == ST_BAD))
    else $error("result carries an unknown status code");

  a_input_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_byte_q) && $stable(phase_q)))
    else $error("stalled byte in the input register was lost or the parser moved on");

  a_acc_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q != SpeedW'(SatMin - WideW'(1)))
    else $error("running value left the saturation range");

endmodule

`default_nettype wire

[tb/tb_speed_command_parser_top.sv]
// Self-checking testbench for the speed command parser: command lines in, checked speeds out.

module tb_speed_command_parser_top;
  import scp_pkg::*;

  localparam longint SatMax = 64'sd2147483647;
  localparam int StuckLimit = 2000;
  localparam int ByteTarget = 1900;

  typedef struct {
    logic signed [SpeedW-1:0] left;
    logic signed [SpeedW-1:0] right;
    status_e                  status;
  } speed_result_t;

  class line_scoreboard;
    phase_e        phase;
    bit            negative;
    longint        acc;
    longint        left_hold;
    speed_result_t pending_q[$];
    int            errors;
    int            n_bytes;
    int            n_results;
    int            n_status[3];

    function new();
      phase     = PH_START;
      negative  = 1'b0;
      acc       = 0;
      left_hold = 0;
      errors    = 0;
      n_bytes   = 0;
      n_results = 0;
      n_status  = '{0, 0, 0};
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= ChZero && b <= ChNine;
    endfunction

    function void finish_line(longint l, longint r, status_e st);
      speed_result_t res;
      res.left   = l[SpeedW-1:0];
      res.right  = r[SpeedW-1:0];
      res.status = st;
      pending_q.push_back(res);
      phase    = PH_START;
      negative = 1'b0;
      acc      = 0;
    endfunction

    function void add_digit(logic [7:0] b);
      longint d;
      longint v;
      d = b;
      d = d - longint'(ChZero);
      v = acc * 10 + (negative ? -d : d);
      if (v > SatMax) begin
        v = SatMax;
      end else if (v < -SatMax) begin
        v = -SatMax;
      end
      acc = v;
    endfunction

    function void begin_number(logic [7:0] b);
      acc      = 0;
      negative = (b == ChMinus);
      if (!negative) begin
        add_digit(b);
      end
    endfunction

    function void note_byte(logic [7:0] b);
      n_bytes++;
      if (b == ChLf) begin
        return;
      end
      if (b == ChCr) begin
        case (phase)
          PH_RIGHT_BODY: finish_line(left_hold, acc, ST_SPEED);
          PH_WAIT_RESET: finish_line(0, 0, ST_RESET);
          default:       finish_line(0, 0, ST_BAD);
        endcase
        return;
      end
      case (phase)
        PH_START: begin
          phase = (b == ChS) ? PH_AFTER_S : ((b == ChR) ? PH_WAIT_RESET : PH_BAD);
        end
        PH_AFTER_S: begin
          phase = (b == ChSpace) ? PH_LEFT_FIRST : PH_BAD;
        end
        PH_LEFT_FIRST, PH_RIGHT_FIRST: begin
          if (b == ChMinus || is_digit(b)) begin
            begin_number(b);
            phase = (phase == PH_LEFT_FIRST) ? PH_LEFT_BODY : PH_RIGHT_BODY;
          end else begin
            phase = PH_BAD;
          end
        end
        PH_LEFT_BODY: begin
          if (b == ChSpace) begin
            left_hold = acc;
            phase     = PH_RIGHT_FIRST;
          end else begin
            add_digit(b);
          end
        end
        PH_RIGHT_BODY: add_digit(b);
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [SpeedW-1:0] l, logic signed [SpeedW-1:0] r,
                               logic [1:0] st);
      speed_result_t want;
      if (pending_q.size() == 0) begin
        $error("Unexpected result beat: left_milli %0d, right_milli %0d, status %0d",
               l, r, st);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      n_results++;
      if (st <= ST_BAD) begin
        n_status[st]++;
      end
      if (l !== want.left) begin
        $error("left_milli: expected %0d, actual %0d", want.left, l);
        errors++;
      end
      if (r !== want.right) begin
        $error("right_milli: expected %0d, actual %0d", want.right, r);
        errors++;
      end
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        errors++;
      end
    endfunction
  endclass

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic [7:0]               rx_byte   = 8'h00;
  logic                     out_ready = 1'b0;
  logic                     in_ready;
  logic                     out_valid;
  logic signed [SpeedW-1:0] left_milli;
  logic signed [SpeedW-1:0] right_milli;
  logic [1:0]               status;

  line_scoreboard sb;
  logic [7:0]     line_q[$];
  bit             quiet     = 1'b0;
  bit             gaps_on   = 1'b1;
  bit             stalls_on = 1'b1;
  int             bytes_sent;
  int             stuck_cycles;

  speed_command_parser_top u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .rx_byte_i     (rx_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .left_milli_o  (left_milli),
    .right_milli_o (right_milli),
    .status_o      (status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_byte(rx_byte);
      end
      if (out_valid && out_ready) begin
        sb.check_result(left_milli, right_milli, status);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= StuckLimit) begin
          $display("Watchdog expired after %0d cycles without a beat.", StuckLimit);
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 63) == 0) begin
        stalls_on = !stalls_on;
      end
      if (rst_n && !quiet && stalls_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_queued();
    logic [7:0] b;
    while (line_q.size() != 0) begin
      b = line_q.pop_front();
      if (!quiet && gaps_on && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      in_valid <= 1'b1;
      rx_byte  <= b;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      bytes_sent++;
    end
  endtask

  function automatic void push_line(string s);
    for (int i = 0; i < s.len(); i++) begin
      line_q.push_back(s[i]);
    end
    line_q.push_back(ChCr);
  endfunction

  function automatic void push_char(logic [7:0] b);
    if ($urandom_range(0, 24) == 0) begin
      line_q.push_back(ChLf);
    end
    line_q.push_back(b);
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == ChCr || b == ChLf || b == ChSpace);
    return b;
  endfunction

  function automatic void push_number();
    int ndig;
    bit neg;
    bit nines;
    neg   = 1'($urandom_range(0, 1));
    ndig  = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 5);
    nines = ($urandom_range(0, 3) == 0);
    if (neg) begin
      push_char(ChMinus);
      if ($urandom_range(0, 15) == 0) begin
        ndig = 0;
      end
    end
    for (int i = 0; i < ndig; i++) begin
      if ((i > 0 || neg) && $urandom_range(0, 39) == 0) begin
        push_char(rand_plain());
      end else if (nines && ndig >= 10) begin
        push_char(ChNine);
      end else begin
        push_char(ChZero + 8'($urandom_range(0, 9)));
      end
    end
  endfunction

  function automatic void build_speed_line();
    push_char(ChS);
    push_char(ChSpace);
    push_number();
    push_char(ChSpace);
    push_number();
    line_q.push_back(ChCr);
  endfunction

  function automatic void build_broken_line();
    int k;
    build_speed_line();
    k = $urandom_range(0, line_q.size() - 2);
    if ($urandom_range(0, 1) == 0) begin
      while (line_q.size() > k) void'(line_q.pop_back());
      line_q.push_back(ChCr);
    end else begin
      line_q[k] = rand_plain();
    end
  endfunction

  initial begin
    int pick;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines: empty line, reset, unknown command, several ways of going wrong,
    // stray line feeds, saturation and the all-zeros and all-ones bytes.
    push_line("");
    push_line("s 12 -34");
    push_line("r");
    push_line("q1");
    push_line("sx 1 2");
    push_line("s a 1");
    push_line("s 12");
    push_line("s 1 ");
    push_line("s 7a -");
    push_line("s\n 5 6\n");
    push_line("s -2147483647 99999999999");
    line_q.push_back(8'h00);
    line_q.push_back(8'hff);
    line_q.push_back(ChCr);
    send_queued();

    while (bytes_sent < ByteTarget) begin
      quiet = (bytes_sent > ByteTarget - 300);
      if ($urandom_range(0, 15) == 0) begin
        gaps_on = !gaps_on;
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        build_speed_line();
      end else if (pick < 70) begin
        push_char(ChR);
        repeat ($urandom_range(0, 4)) push_char(rand_plain());
        line_q.push_back(ChCr);
      end else if (pick < 85) begin
        build_broken_line();
      end else begin
        repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
        line_q.push_back(ChCr);
      end
      send_queued();
    end
    in_valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Fed %0d bytes and checked %0d lines: %0d speed commands, %0d resets, %0d malformed.",
             sb.n_bytes, sb.n_results, sb.n_status[ST_SPEED], sb.n_status[ST_RESET],
             sb.n_status[ST_BAD]);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[speed_command_parser_top.f]
src/scp_pkg.sv
src/speed_command_parser_top.sv
tb/tb_speed_command_parser_top.sv
